// File: rtl/core/mwlfo_pkg.sv
// shared types and constants of the multi-waveform lfo
`timescale 1ns / 1ps
`default_nettype none

package mwlfo_pkg;

	// waveform codes of the waveform_select register
	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_TRIANGLE = 3'd1,
		WAVE_SAWTOOTH = 3'd2,
		WAVE_SQUARE   = 3'd3,
		WAVE_HOLD     = 3'd4
	} wave_sel_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_WAVE_SEL   = 2'd1,
		CFG_NOISE_SEED = 2'd2
	} cfg_index_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned SAMPLE_W    = 16;

	// galois lfsr feedback mask, right shifting
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

	// pi/2 in q30, used to build the quarter-wave table
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// taylor series divisors (2n)(2n+1) for n = 1..7
	localparam longint unsigned TAYLOR_DIV [7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

`default_nettype wire

// File: rtl/core/mwlfo_if.sv
// valid/ready channel interfaces for the lfo tick and sample items
`timescale 1ns / 1ps
`default_nettype none

interface mwlfo_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface mwlfo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mwlfo_shaper.sv
// deterministic waveform shaping: sine rom, triangle, sawtooth, square
`timescale 1ns / 1ps
`default_nettype none

module mwlfo_shaper
	import mwlfo_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  wire logic [31:0]                phase,
	input  wire logic [2:0]                 sel,
	output logic signed [SAMPLE_W-1:0]      wave
);

	localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned PW = 30 + AW;
	localparam logic [AW-1:0] DEPTH_A = AW'(SINE_TABLE_DEPTH);

	// one quarter-wave entry, round(32768*sin(pi/2*i/D)) capped at 32767, via q30 taylor series
	function automatic logic [14:0] sine_entry(input int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned q;
		longint          sum;
		x    = (HALF_PI_Q30 * longint'(i) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 0; n < 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n % 2) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (longint'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[14:0];
	endfunction

	logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [14:0] ENTRY = sine_entry(g);
		assign sine_rom[g] = ENTRY;
	end

	logic [PW-1:0]               idx_prod;
	logic [AW-1:0]               idx;
	logic [AW-1:0]               rom_addr;
	logic signed [SAMPLE_W-1:0]  sine_mag;
	logic signed [SAMPLE_W-1:0]  sine_val;
	logic [15:0]                 tri_low;
	logic signed [SAMPLE_W-1:0]  tri_val;

	// table index from the 30 bits within the quarter
	assign idx_prod = {{AW{1'b0}}, phase[29:0]} * PW'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[PW-1:30];
	// odd quarters run the table backwards
	assign rom_addr = phase[30] ? (DEPTH_A - idx) : idx;
	assign sine_mag = {1'b0, sine_rom[rom_addr]};
	assign sine_val = phase[31] ? -sine_mag : sine_mag;

	// triangle: rising half is a-32768, falling half 32768-b with the peak saturated
	assign tri_low = phase[30:15];
	always_comb begin
		if (!phase[31]) begin
			tri_val = {~phase[30], phase[29:15]};
		end else if (tri_low == 16'd0) begin
			tri_val = SAMPLE_MAX;
		end else begin
			tri_val = 16'h8000 - tri_low;
		end
	end

	always_comb begin
		unique case (sel)
			WAVE_SINE:     wave = sine_val;
			WAVE_TRIANGLE: wave = tri_val;
			WAVE_SAWTOOTH: wave = {~phase[31], phase[30:16]};
			WAVE_SQUARE:   wave = phase[31] ? SAMPLE_MIN : SAMPLE_MAX;
			default:       wave = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/multi_waveform_lfo.sv
// top level of the multi-waveform low-frequency oscillator
`timescale 1ns / 1ps
`default_nettype none

// Phase-accumulator LFO. Every tick item accepted on the tick channel yields
// exactly one signed Q1.15 sample item on the wave channel in the next cycle,
// and a new tick is taken in every cycle (one item per cycle sustained) as
// long as the output register is empty or being drained in the same cycle.
// The per-tick path runs from the phase, LFSR and held-value registers
// through the phase-versus-step compare and the quarter-wave sine lookup into
// the sample register. The phase is PHASE_BITS wide; the 32-bit phase_step
// register is shifted to that width and the top 32 phase bits drive the
// waveforms. Waveforms: 0 sine (quarter-wave table of SINE_TABLE_DEPTH+1
// entries built at elaboration), 1 triangle, 2 sawtooth, 3 square,
// 4 sample-and-hold, which steps a 32-bit Galois LFSR and takes its upper
// half on a tick whose phase lies below the step; codes 5 to 7 give zero.
// A restart tick clears the phase and held value and reloads the LFSR from
// noise_seed (zero seed counts as 1) before its sample is formed; only a
// restart loads a new noise_seed. The user must write configuration via
// cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not check it.

module multi_waveform_lfo
	import mwlfo_pkg::*;
#(
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	mwlfo_tick_if.sink                  tick,
	mwlfo_sample_if.source              wave
);

	// configuration registers
	logic [31:0] step_q;
	logic [2:0]  sel_q;
	logic [31:0] seed_q;

	// oscillator state
	logic [PHASE_BITS-1:0]      phase_q;
	logic signed [SAMPLE_W-1:0] held_q;
	logic [31:0]                lfsr_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic                       accept;
	logic [31:0]                seed_eff;
	logic [PHASE_BITS-1:0]      phase_cur;
	logic signed [SAMPLE_W-1:0] held_cur;
	logic [31:0]                lfsr_cur;
	logic [PHASE_BITS-1:0]      step_scaled;
	logic [31:0]                phase_top;
	logic                       wrapped;
	logic [31:0]                lfsr_step;
	logic                       draw;
	logic signed [SAMPLE_W-1:0] shaped;
	logic signed [SAMPLE_W-1:0] sample_nxt;

	// input can enter while the output register empties in the same cycle
	assign tick.ready = !out_valid_q || wave.ready;
	assign accept     = tick.valid && tick.ready;

	assign wave.valid      = out_valid_q;
	assign wave.sample_out = sample_q;

	// configuration writes, index beyond the list ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			sel_q  <= WAVE_SINE;
			seed_q <= 32'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PHASE_STEP: step_q <= cfg_wdata[31:0];
				CFG_WAVE_SEL:   sel_q  <= cfg_wdata[2:0];
				CFG_NOISE_SEED: seed_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign seed_eff = (seed_q != 32'd0) ? seed_q : 32'd1;

	// restart applies before this tick's sample
	assign phase_cur = tick.restart ? '0 : phase_q;
	assign held_cur  = tick.restart ? '0 : held_q;
	assign lfsr_cur  = tick.restart ? seed_eff : lfsr_q;

	// step scaled to the accumulator width, top 32 phase bits for shaping
	if (PHASE_BITS >= 32) begin : g_wide
		assign step_scaled = PHASE_BITS'(step_q) << (PHASE_BITS - 32);
		assign phase_top   = phase_cur[PHASE_BITS-1 -: 32];
	end else begin : g_narrow
		assign step_scaled = step_q[31 -: PHASE_BITS];
		assign phase_top   = {phase_cur, {(32-PHASE_BITS){1'b0}}};
	end

	// phase below the step means it has just wrapped
	assign wrapped = phase_cur < step_scaled;

	// one galois step
	assign lfsr_step = {1'b0, lfsr_cur[31:1]} ^ (lfsr_cur[0] ? LFSR_MASK : 32'd0);
	assign draw      = (sel_q == WAVE_HOLD) && wrapped;

	mwlfo_shaper #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_shaper (
		.phase (phase_top),
		.sel   (sel_q),
		.wave  (shaped)
	);

	always_comb begin
		if (sel_q == WAVE_HOLD) begin
			sample_nxt = draw ? $signed(lfsr_step[31:16]) : held_cur;
		end else begin
			sample_nxt = shaped;
		end
	end

	// oscillator state advances once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			held_q  <= '0;
			lfsr_q  <= 32'd1;
		end else if (accept) begin
			phase_q <= phase_cur + step_scaled;
			held_q  <= sample_nxt;
			lfsr_q  <= draw ? lfsr_step : lfsr_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (wave.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sample payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_nxt;
		end
	end

endmodule

`default_nettype wire

// File: sim/lfo_sample_checker.sv
// scoreboard with its own oscillator predictor for the multi-waveform lfo
`timescale 1ns / 1ps

module lfo_sample_checker
	import mwlfo_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	mwlfo_tick_if                  tick,
	mwlfo_sample_if                wave,
	output int unsigned            fail_count,
	output int unsigned            pending,
	output int unsigned            checked
);

	localparam int unsigned TABLE_DEPTH  = 256;
	localparam int unsigned REPORT_LIMIT = 40;
	localparam int          HALF_SCALE   = 32768;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [2:0]                 wave_code;
		int unsigned                tick_no;
	} sample_exp_t;

	int          quarter_sine [0:TABLE_DEPTH];
	sample_exp_t predicted_samples [$];

	logic [31:0]                step_reg;
	logic [31:0]                seed_reg;
	logic [2:0]                 wave_reg;
	logic [31:0]                phase;
	logic [31:0]                lfsr;
	logic signed [SAMPLE_W-1:0] held;
	int unsigned                mismatches;
	int unsigned                ticks_seen;
	int unsigned                samples_seen;

	// quarter-wave table, q30 taylor series rounded to q15
	initial begin : build_table
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		int unsigned     i;
		int unsigned     n;
		for (i = 0; i <= TABLE_DEPTH; i++) begin
			x = (HALF_PI_Q30 * i + TABLE_DEPTH / 2) / TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (n = 0; n < 7; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
				if (n % 2 == 0)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			acc = (acc + (1 << 14)) >>> 15;
			quarter_sine[i] = (acc > int'(SAMPLE_MAX)) ? int'(SAMPLE_MAX) : int'(acc);
		end
	end

	// one tick of the oscillator: sample from the current phase, then advance
	function automatic logic signed [SAMPLE_W-1:0] advance_oscillator(input logic restart);
		int         v;
		int         a;
		logic [7:0] idx;
		logic       lsb;
		if (restart) begin
			phase = '0;
			held = '0;
			lfsr = (seed_reg == '0) ? 32'd1 : seed_reg;
		end
		case (wave_reg)
		WAVE_SINE: begin
			idx = phase[29:22];
			v = phase[30] ? quarter_sine[TABLE_DEPTH - idx] : quarter_sine[idx];
			if (phase[31])
				v = -v;
		end
		WAVE_TRIANGLE: begin
			a = phase >> 15;
			v = phase[31] ? 3 * HALF_SCALE - a : a - HALF_SCALE;
			if (v > int'(SAMPLE_MAX))
				v = int'(SAMPLE_MAX);
		end
		WAVE_SAWTOOTH: begin
			a = phase >> 16;
			v = a - HALF_SCALE;
		end
		WAVE_SQUARE: begin
			v = phase[31] ? int'(SAMPLE_MIN) : int'(SAMPLE_MAX);
		end
		WAVE_HOLD: begin
			// new draw only on the tick right after a wrap
			if (phase < step_reg) begin
				lsb = lfsr[0];
				lfsr = lfsr >> 1;
				if (lsb)
					lfsr = lfsr ^ LFSR_MASK;
				held = lfsr[31:16];
			end
			v = held;
		end
		default: v = 0;
		endcase
		phase = phase + step_reg;
		held = v[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		sample_exp_t want;
		if (!arst_n) begin
			step_reg = '0;
			wave_reg = WAVE_SINE;
			seed_reg = 32'd1;
			phase = '0;
			held = '0;
			lfsr = 32'd1;
			predicted_samples.delete();
			pending <= 0;
		end else begin
			// a tick uses the settings from before any write at this edge
			if (tick.valid && tick.ready) begin
				want.wave_code = wave_reg;
				want.tick_no = ticks_seen;
				want.sample = advance_oscillator(tick.restart);
				ticks_seen++;
				predicted_samples.push_back(want);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
				CFG_PHASE_STEP: step_reg = cfg_wdata;
				CFG_WAVE_SEL:   wave_reg = cfg_wdata[2:0];
				CFG_NOISE_SEED: seed_reg = cfg_wdata;
				default: ;
				endcase
			end
			if (wave.valid && wave.ready) begin
				samples_seen++;
				if (predicted_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d came with no tick pending",
						wave.sample_out));
				end else begin
					want = predicted_samples.pop_front();
					if (wave.sample_out !== want.sample)
						report_mismatch($sformatf(
							"tick %0d wave code %0d: sample_out %0d, predicted %0d",
							want.tick_no, want.wave_code, wave.sample_out, want.sample));
				end
			end
			pending <= predicted_samples.size();
			fail_count <= mismatches;
			checked <= samples_seen;
		end
	end

endmodule

// File: sim/multi_waveform_lfo_tb.sv
// top of the multi-waveform lfo testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module multi_waveform_lfo_tb;
	import mwlfo_pkg::*;

	localparam int unsigned RANDOM_TICKS = 1000;
	localparam longint      TIMEOUT_NS   = 4_000_000;

	// the one register index the block does not implement
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
	// highest waveform code; the ones above WAVE_HOLD give a zero output
	localparam logic [2:0] WAVE_CODE_TOP = 3'd7;

	// how the sample receiver throttles the wave channel
	typedef enum int unsigned {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC,
		RX_LONG
	} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;

	rx_mode_t    rx_mode = RX_OPEN;
	logic [2:0]  cur_wave = WAVE_SINE;
	int unsigned wave_ticks [8];
	int unsigned restarts;
	int unsigned random_ticks;
	int unsigned writes;

	mwlfo_tick_if   tick ();
	mwlfo_sample_if wave ();

	multi_waveform_lfo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick),
		.wave      (wave)
	);

	// watches both channels and the register port, predicts every sample
	lfo_sample_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.tick       (tick),
		.wave       (wave),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample receiver, throttles on its own pattern regardless of the sender
	initial begin : receiver
		int unsigned beat;
		int unsigned hold_left;
		wave.ready = 1'b0;
		beat = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			beat++;
			case (rx_mode)
			RX_OPEN: wave.ready <= 1'b1;
			RX_RANDOM: wave.ready <= ($urandom_range(0, 99) < 70);
			// stalls while the beat count modulo 7 is below 2
			RX_PERIODIC: wave.ready <= ((beat % 7) > 1);
			// mostly open, now and then a long stall
			RX_LONG: begin
				if (hold_left != 0) begin
					hold_left--;
					wave.ready <= 1'b0;
				end else if ($urandom_range(0, 19) == 0) begin
					hold_left = $urandom_range(4, 24);
					wave.ready <= 1'b0;
				end else begin
					wave.ready <= 1'b1;
				end
			end
			default: wave.ready <= 1'b1;
			endcase
		end
	end

	// register write, one cycle of enable, then the enable is dropped before returning
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == CFG_WAVE_SEL)
			cur_wave = data[2:0];
		writes++;
	endtask

	// offer one tick item and hold it until the block takes it
	task automatic send_tick(input logic rst);
		tick.valid <= 1'b1;
		tick.restart <= rst;
		@(posedge clk);
		while (!tick.ready)
			@(posedge clk);
		wave_ticks[cur_wave]++;
		if (rst)
			restarts++;
	endtask

	// stop sending and wait until every predicted sample has been taken;
	// the block holds one pipeline stage
	task automatic drain_samples();
		tick.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// a run of ticks, optionally in bursts, optionally pausing halfway until
	// the output side is empty
	task automatic run_ticks(input int unsigned count, input int unsigned restart_pct,
		input bit bursty, input bit hold_off);
		int unsigned k;
		int unsigned burst_left;
		burst_left = $urandom_range(1, 24);
		for (k = 0; k < count; k++) begin
			if (hold_off && k == count / 2) begin
				tick.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end else if (bursty && burst_left == 0) begin
				// restart is a don't-care while valid is low, so let it toggle
				tick.valid <= 1'b0;
				tick.restart <= $urandom_range(0, 1);
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			send_tick($urandom_range(0, 99) < restart_pct);
			random_ticks++;
			if (burst_left != 0)
				burst_left--;
		end
	endtask

	// waveform register word: the code in the low bits, junk above it
	function automatic logic [CFG_DATA_W-1:0] wave_word(input logic [2:0] code);
		return ($urandom() & ~32'h7) | code;
	endfunction

	// step mix: extremes, slow sweeps and anything at all
	function automatic logic [CFG_DATA_W-1:0] pick_step();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 32'h8000_0000;
		3: return 32'd1;
		4: return $urandom_range(1, 32'h00FF_FFFF);
		5: return $urandom_range(1, 32'h0FFF_FFFF);
		default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_code();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(WAVE_HOLD + 1, WAVE_CODE_TOP);
		return $urandom_range(WAVE_SINE, WAVE_HOLD);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_seed();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int unsigned phase_no;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_PHASE_STEP;
		cfg_wdata = '0;
		tick.valid = 1'b0;
		tick.restart = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----

		// settings straight out of reset: sine, zero step, so the output sits at zero
		send_tick(1'b0);
		send_tick(1'b1);
		drain_samples();

		// sample-and-hold with zero step never wraps, so the held zero stays
		write_reg(CFG_WAVE_SEL, wave_word(WAVE_HOLD));
		send_tick(1'b0);
		send_tick(1'b0);
		drain_samples();

		// quarter-cycle step walks the sine through all four quarters,
		// including the clamped peak at the table end
		write_reg(CFG_PHASE_STEP, 32'h4000_0000);
		write_reg(CFG_WAVE_SEL, wave_word(WAVE_SINE));
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		drain_samples();

		// eighth-period triangle reaches the half-period peak, which saturates
		write_reg(CFG_WAVE_SEL, wave_word(WAVE_TRIANGLE));
		write_reg(CFG_PHASE_STEP, 32'h2000_0000);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		drain_samples();

		// largest step on the sawtooth gives both ends of the ramp
		write_reg(CFG_WAVE_SEL, wave_word(WAVE_SAWTOOTH));
		write_reg(CFG_PHASE_STEP, '1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		drain_samples();

		// half-cycle square flips every tick
		write_reg(CFG_WAVE_SEL, wave_word(WAVE_SQUARE));
		write_reg(CFG_PHASE_STEP, 32'h8000_0000);
		send_tick(1'b0);
		send_tick(1'b0);
		drain_samples();

		// zero seed loads the noise register as one; quarter step wraps every fourth tick
		write_reg(CFG_NOISE_SEED, '0);
		write_reg(CFG_WAVE_SEL, wave_word(WAVE_HOLD));
		write_reg(CFG_PHASE_STEP, 32'h4000_0000);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		drain_samples();

		// a new seed must not reach the noise register until a restart
		write_reg(CFG_NOISE_SEED, 32'hA5C3_0F96);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_samples();

		// unused waveform codes read zero; a write to the spare index is dropped
		write_reg(CFG_WAVE_SEL, wave_word($urandom_range(WAVE_HOLD + 1, WAVE_CODE_TOP)));
		write_reg(CFG_SPARE_INDEX, $urandom());
		send_tick(1'b0);
		send_tick(1'b1);
		drain_samples();

		// ---- random part ----
		// every phase may reprogram registers while idle, picks a receiver pattern
		// and sends a run of ticks; the first one pauses midway, later ones at times
		phase_no = 0;
		random_ticks = 0;
		while (random_ticks < RANDOM_TICKS) begin
			if (phase_no == 0 || $urandom_range(0, 3) != 0)
				write_reg(CFG_PHASE_STEP, pick_step());
			if (phase_no == 0 || $urandom_range(0, 2) != 0)
				write_reg(CFG_WAVE_SEL, wave_word(pick_code()));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_NOISE_SEED, pick_seed());
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_SPARE_INDEX, $urandom());
			rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_LONG));
			run_ticks($urandom_range(16, 64), ($urandom_range(0, 1) != 0) ? 3 : 12,
				$urandom_range(0, 2) != 0, phase_no == 0 || $urandom_range(0, 5) == 0);
			drain_samples();
			phase_no++;
		end

		repeat (4) @(posedge clk);
		$display("summary: %0d ticks (%0d with restart) over %0d random phases,",
			wave_ticks.sum(), restarts, phase_no);
		$display("summary: %0d samples checked, %0d register writes", checked, writes);
		$display("summary: ticks per waveform code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			wave_ticks[0], wave_ticks[1], wave_ticks[2], wave_ticks[3],
			wave_ticks[4], wave_ticks[5], wave_ticks[6], wave_ticks[7]);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("run timed out after %0d ns", TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

endmodule
